[sv/keypad_change_event_detector_defines.svh]
// assertion macros shared by the keypad change event detector rtl
// no dependencies; included by modules that carry assertions
`ifndef KEYPAD_CHANGE_EVENT_DETECTOR_DEFINES_SVH
`define KEYPAD_CHANGE_EVENT_DETECTOR_DEFINES_SVH

// condition implies consequence in the same cycle
`define KCED_ASSERT_SAME(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("kced assertion failed");

// condition implies consequence in the next cycle
`define KCED_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("kced assertion failed");

`endif

[sv/kced_pkg.sv]
// shared constants, types and helpers of the keypad change event detector
// no dependencies
`default_nettype none

package kced_pkg;

  localparam int NUM_WORDS   = 5;
  localparam int IN_FIELDS   = 5;
  localparam int WORD_W      = 16;
  localparam int MATRIX_BITS = 15;
  localparam int MATRIX_KEYS = NUM_WORDS * MATRIX_BITS;
  localparam int TOTAL_KEYS  = NUM_WORDS * WORD_W;
  localparam int KEY_W       = 7;
  localparam int BANK_W      = 2;
  localparam int BANK_SIZE   = 25;

  localparam logic [BANK_W-1:0]      BANK_EXTRA = 2'd3;
  localparam logic [BANK_W-1:0]      BANK_CLIP  = 2'd2;
  localparam logic [MATRIX_BITS-1:0] IDLE_RESET = 15'h001F;
  localparam logic [WORD_W-1:0]      MATRIX_MASK = 16'h7FFF;

  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  // per key inputs of one cell
  typedef struct packed {
    logic pressed;
    logic idle_pressed;
    logic suppress;
  } key_in_t;

  // baseline status handed to the key row
  typedef struct packed {
    logic                                   active;
    logic [NUM_WORDS-1:0][MATRIX_BITS-1:0]  bits;
  } base_t;

  // bank of a key index; matrix banks clip at two
  function automatic logic [BANK_W-1:0] key_bank(input logic [KEY_W-1:0] key);
    logic [KEY_W:0] k;
    k = {1'b0, key};
    if (k >= (KEY_W+1)'(MATRIX_KEYS)) begin
      return BANK_EXTRA;
    end else if (k >= (KEY_W+1)'(2 * BANK_SIZE)) begin
      return BANK_CLIP;
    end else if (k >= (KEY_W+1)'(BANK_SIZE)) begin
      return 2'd1;
    end else begin
      return 2'd0;
    end
  endfunction

endpackage

`default_nettype wire

[sv/kced_key_cell.sv]
// one key of the change detector row: last state bit and first-change chain link
// depends on kced_pkg
`default_nettype none

module kced_key_cell (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             scan_i,
  input  wire logic             latch_full_i,
  input  wire kced_pkg::key_in_t key_i,
  input  wire logic             found_i,
  output logic                  found_o,
  output logic                  hit_o,
  output logic                  pressed_o
);
  import kced_pkg::*;

  logic was_down_q, was_down_d;
  logic change;

  // pressed state after baseline suppression
  assign pressed_o = key_i.pressed &
                     ~(key_i.suppress & (key_i.pressed == key_i.idle_pressed));
  assign change    = pressed_o != was_down_q;

  // first change in key order when the latch is empty
  assign hit_o   = change & ~found_i & ~latch_full_i;
  assign found_o = found_i | change;

  // full latch tracks every change, empty latch only the first one
  always_comb begin
    was_down_d = was_down_q;
    if (scan_i && (latch_full_i ? change : hit_o)) begin
      was_down_d = pressed_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_down_q <= 1'b0;
    end else begin
      was_down_q <= was_down_d;
    end
  end

endmodule

`default_nettype wire

[sv/kced_baseline.sv]
// baseline enable register, idle baseline capture and suppression status
// depends on kced_pkg
`default_nettype none

module kced_baseline (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire logic                                           cfg_we_i,
  input  wire logic                                           cfg_wdata_i,
  input  wire logic                                           scan_i,
  input  wire logic [kced_pkg::NUM_WORDS-1:0][kced_pkg::WORD_W-1:0] words_i,
  output kced_pkg::base_t                                     base_o
);
  import kced_pkg::*;

  logic                                  enable_q;
  logic                                  captured_q, captured_d;
  logic [NUM_WORDS-1:0][MATRIX_BITS-1:0] idle_q, idle_d;
  logic                                  all_idle;
  logic                                  capture_ok;
  logic [NUM_WORDS-1:0][MATRIX_BITS-1:0] words_low;

  // every matrix bit of the scan released
  always_comb begin
    all_idle = 1'b1;
    for (int i = 0; i < NUM_WORDS; i++) begin
      words_low[i] = words_i[i][MATRIX_BITS-1:0];
      if ((words_i[i] & MATRIX_MASK) != MATRIX_MASK) begin
        all_idle = 1'b0;
      end
    end
  end

  assign capture_ok = enable_q & ~captured_q & all_idle;

  // the capturing scan already compares against its own words
  assign base_o.active = enable_q & (captured_q | capture_ok);
  assign base_o.bits   = capture_ok ? words_low : idle_q;

  // capture next state
  always_comb begin
    captured_d = captured_q;
    idle_d     = idle_q;
    if (scan_i && capture_ok) begin
      captured_d = 1'b1;
      idle_d     = words_low;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      captured_q <= 1'b0;
      idle_q     <= {NUM_WORDS{IDLE_RESET}};
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      captured_q <= captured_d;
      idle_q     <= idle_d;
    end
  end

endmodule

`default_nettype wire

[sv/keypad_change_event_detector.sv]
// keypad change event detector: one request per cycle; a pop waits while an untaken result is held.
// a scan updates key state and the event latch at its accepting edge.
// a pop result appears on the output register in the cycle after acceptance.
// the first-change search is one row of key cells with a ripple chain.
// reset clears key state, latch, baseline and the enable register at once.
`default_nettype none

`include "keypad_change_event_detector_defines.svh"

module keypad_change_event_detector (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          opcode_i,
  input  wire logic [kced_pkg::WORD_W-1:0]   snap_word0_i,
  input  wire logic [kced_pkg::WORD_W-1:0]   snap_word1_i,
  input  wire logic [kced_pkg::WORD_W-1:0]   snap_word2_i,
  input  wire logic [kced_pkg::WORD_W-1:0]   snap_word3_i,
  input  wire logic [kced_pkg::WORD_W-1:0]   snap_word4_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               got_event_o,
  output logic [kced_pkg::BANK_W-1:0]        event_bank_o,
  output logic [kced_pkg::KEY_W-1:0]         key_number_o,
  output logic                               key_down_o
);
  import kced_pkg::*;

  logic [WORD_W-1:0]                 in_words [IN_FIELDS];
  logic [NUM_WORDS-1:0][WORD_W-1:0]  words;
  logic                              fire, scan_fire, pop_fire;
  base_t                             base;
  key_in_t [TOTAL_KEYS-1:0]          key_in;
  logic [TOTAL_KEYS:0]               found;
  logic [TOTAL_KEYS-1:0]             hit, pressed;
  logic [KEY_W-1:0]                  hit_key;
  logic                              hit_down;
  logic                              any_hit;

  logic                              full_q, full_d;
  logic [BANK_W-1:0]                 held_bank_q, held_bank_d;
  logic [KEY_W-1:0]                  held_key_q, held_key_d;
  logic                              held_down_q, held_down_d;
  logic                              out_valid_q, out_valid_d;
  logic                              got_q, got_d;
  logic [BANK_W-1:0]                 bank_q, bank_d;
  logic [KEY_W-1:0]                  key_q, key_d;
  logic                              down_q, down_d;

  // request handshake; scans never touch the output register
  assign in_ready_o = (op_e'(opcode_i) == OP_SCAN) | ~out_valid_q | out_ready_i;
  assign fire       = in_valid_i & in_ready_o;
  assign scan_fire  = fire & (op_e'(opcode_i) == OP_SCAN);
  assign pop_fire   = fire & (op_e'(opcode_i) == OP_POP);

  // snapshot words; words past the input ports read all idle
  assign in_words[0] = snap_word0_i;
  assign in_words[1] = snap_word1_i;
  assign in_words[2] = snap_word2_i;
  assign in_words[3] = snap_word3_i;
  assign in_words[4] = snap_word4_i;

  for (genvar i = 0; i < NUM_WORDS; i++) begin : g_word
    if (i < IN_FIELDS) begin : g_port
      assign words[i] = in_words[i];
    end else begin : g_idle
      assign words[i] = '1;
    end
  end

  kced_baseline u_baseline (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .scan_i      (scan_fire),
    .words_i     (words),
    .base_o      (base)
  );

  // row of key cells in key order, matrix keys first
  assign found[0] = 1'b0;

  for (genvar k = 0; k < TOTAL_KEYS; k++) begin : g_key
    if (k < MATRIX_KEYS) begin : g_matrix
      localparam int W = k / MATRIX_BITS;
      localparam int B = k % MATRIX_BITS;
      assign key_in[k].pressed      = ~words[W][B];
      assign key_in[k].idle_pressed = ~base.bits[W][B];
      assign key_in[k].suppress     = base.active;
    end else begin : g_extra
      localparam int W = k - MATRIX_KEYS;
      assign key_in[k].pressed      = ~words[W][MATRIX_BITS];
      assign key_in[k].idle_pressed = 1'b0;
      assign key_in[k].suppress     = 1'b0;
    end

    kced_key_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .scan_i       (scan_fire),
      .latch_full_i (full_q),
      .key_i        (key_in[k]),
      .found_i      (found[k]),
      .found_o      (found[k+1]),
      .hit_o        (hit[k]),
      .pressed_o    (pressed[k])
    );
  end

  // encode the one-hot first change
  always_comb begin
    hit_key  = '0;
    hit_down = 1'b0;
    for (int k = 0; k < TOTAL_KEYS; k++) begin
      hit_key  = hit_key | ({KEY_W{hit[k]}} & KEY_W'(k));
      hit_down = hit_down | (hit[k] & pressed[k]);
    end
  end

  assign any_hit = |hit;

  // event latch
  always_comb begin
    full_d      = full_q;
    held_bank_d = held_bank_q;
    held_key_d  = held_key_q;
    held_down_d = held_down_q;
    if (scan_fire && any_hit) begin
      full_d      = 1'b1;
      held_bank_d = key_bank(hit_key);
      held_key_d  = hit_key;
      held_down_d = hit_down;
    end else if (pop_fire) begin
      full_d = 1'b0;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    got_d       = got_q;
    bank_d      = bank_q;
    key_d       = key_q;
    down_d      = down_q;
    if (pop_fire) begin
      out_valid_d = 1'b1;
      got_d       = full_q;
      bank_d      = full_q ? held_bank_q : '0;
      key_d       = full_q ? held_key_q : '0;
      down_d      = full_q & held_down_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q      <= 1'b0;
      held_bank_q <= '0;
      held_key_q  <= '0;
      held_down_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      full_q      <= full_d;
      held_bank_q <= held_bank_d;
      held_key_q  <= held_key_d;
      held_down_q <= held_down_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    got_q  <= got_d;
    bank_q <= bank_d;
    key_q  <= key_d;
    down_q <= down_d;
  end

  assign out_valid_o  = out_valid_q;
  assign got_event_o  = got_q;
  assign event_bank_o = bank_q;
  assign key_number_o = key_q;
  assign key_down_o   = down_q;

  // checks
  `KCED_ASSERT_SAME(a_hit_onehot, clk_i, rst_ni, 1'b1, $onehot0(hit))
  `KCED_ASSERT_SAME(a_no_hit_when_full, clk_i, rst_ni, full_q, hit == '0)
  `KCED_ASSERT_NEXT(a_scan_keeps_full, clk_i, rst_ni, scan_fire && full_q, full_q)
  `KCED_ASSERT_NEXT(a_pop_clears, clk_i, rst_ni, pop_fire, !full_q && out_valid_q)
  `KCED_ASSERT_SAME(a_empty_result_zero, clk_i, rst_ni, out_valid_q && !got_q,
                    key_q == '0 && bank_q == '0 && !down_q)

endmodule

`default_nettype wire
